### src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWLPE_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWLPE_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/swlpe_pkg.sv
// Package of constants and helper functions for the single-wire LED pulse encoder.
package swlpe_pkg;

    // Fixed field widths.
    localparam int WORD_W = 32;
    localparam int CFG_W  = 12;
    localparam int POS_W  = 6;
    localparam int ADDR_W = 4;
    localparam int APB_W  = 32;

    // Defaults for the top-level parameters.
    localparam int DEF_FRAME_BYTES = 4;
    localparam int DEF_TIMER_BITS  = 13;

    // Phase codes of the line sequencer.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HDR_HIGH = 3'd1;
    localparam logic [2:0] PH_HDR_LOW  = 3'd2;
    localparam logic [2:0] PH_BIT_HIGH = 3'd3;
    localparam logic [2:0] PH_BIT_LOW  = 3'd4;
    localparam logic [2:0] PH_ONE_HIGH = 3'd5;
    localparam logic [2:0] PH_ONE_LOW  = 3'd6;
    localparam logic [2:0] PH_ZERO_LOW = 3'd7;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_PULSE    = 2'd0;
    localparam logic [1:0] REG_GAP_ONE  = 2'd1;
    localparam logic [1:0] REG_GAP_ZERO = 2'd2;

    // Input mode codes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Bit positions of the result fields in m_tdata.
    localparam int OUT_LEVEL_BIT   = 0;
    localparam int OUT_BUSY_BIT    = 1;
    localparam int OUT_REFUSED_BIT = 2;

    // Position, counted from the MSB, of the first bit equal to target.
    // Returns WORD_W when no such bit exists.
    function automatic logic [POS_W-1:0] lead_pos(input logic [WORD_W-1:0] word,
                                                  input logic target);
        logic [POS_W-1:0] pos;
        pos = POS_W'(WORD_W);
        for (int i = 0; i < WORD_W; i++) begin
            if (word[i] == target) begin
                pos = POS_W'(WORD_W - 1 - i);
            end
        end
        return pos;
    endfunction

endpackage

### src/single_wire_led_pulse_encoder_core.sv
// Single-wire LED pulse encoder: frame load, microsecond ticks and line level output.
//
//  Channel   Direction  Payload                                    Handshake
//  s_        in         tuser: mode; tdata: gs_word                tvalid/tready
//  m_        out        tdata: line_level, busy_res, load_refused  tvalid/tready
//  APB       in/out     pulse_ticks, gap_one_ticks, gap_zero_ticks psel/penable/pready
//
// The sequencer state and the result register are updated at the edge that
// accepts the transfer, so one item enters per cycle while s_tready is high.
// Runs of zero-length segments are skipped within the same transfer by a leading-bit
// search over the remaining frame word.
// Reset (aresetn low, synchronous) empties the result register and idles the line.
// s_tready is low only while a result is held and m_tready is low.
module single_wire_led_pulse_encoder_core #(
    parameter int FRAME_BYTES = swlpe_pkg::DEF_FRAME_BYTES,
    parameter int TIMER_BITS  = swlpe_pkg::DEF_TIMER_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swlpe_pkg::WORD_W-1:0]  s_tdata,   // [31:0] gs_word
    input  logic                          s_tuser,   // [0] mode
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] line_level, [1] busy_res,
                                                     // [2] load_refused, [7:3] zero
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swlpe_pkg::ADDR_W-1:0]  paddr,
    input  logic [swlpe_pkg::APB_W-1:0]   pwdata,
    output logic [swlpe_pkg::APB_W-1:0]   prdata,
    output logic                          pready
);

    localparam int BIT_TOTAL = FRAME_BYTES * 8;
    localparam int BW        = $clog2(BIT_TOTAL + 1);
    localparam int TB        = TIMER_BITS;
    localparam int SW        = (TB > swlpe_pkg::CFG_W + 1) ? TB : swlpe_pkg::CFG_W + 1;
    localparam int CW        = (BW > swlpe_pkg::POS_W) ? BW : swlpe_pkg::POS_W;
    localparam int WW        = swlpe_pkg::WORD_W;
    localparam logic [SW-1:0] TMAX_EXT = SW'({TB{1'b1}});

    // Configuration registers.
    logic [swlpe_pkg::CFG_W-1:0] pulse_reg;
    logic [swlpe_pkg::CFG_W-1:0] gap_one_reg;
    logic [swlpe_pkg::CFG_W-1:0] gap_zero_reg;

    // Sequencer state.
    logic [2:0]    phase_reg, phase_next;
    logic [TB-1:0] timer_reg, timer_next;
    logic [WW-1:0] shift_reg, shift_next;
    logic [BW-1:0] bits_reg, bits_next;
    logic          level_reg, level_next;

    // Result register.
    logic          m_valid_reg;
    logic [2:0]    result_reg, result_next;
    logic          refused;

    logic          s_accept;
    logic          cfg_write;

    // Segment lengths, saturated to the timer width.
    logic [TB-1:0] seg_p, seg_hl, seg_g1, seg_g0;
    logic          p_nz, hl_nz, g1_nz, g0_nz;

    // Advance path signals.
    logic [2:0]    adv_from;
    logic [WW-1:0] adv_shift_in;
    logic [BW-1:0] adv_bits_in;
    logic [2:0]    adv_phase;
    logic [TB-1:0] adv_timer;
    logic [WW-1:0] adv_shift;
    logic [BW-1:0] adv_bits;
    logic          adv_level;

    // Bit entry signals.
    logic [WW-1:0]             ent_shift_in;
    logic [BW-1:0]             ent_bits_in;
    logic [2:0]                ent_phase;
    logic [TB-1:0]             ent_timer;
    logic [WW-1:0]             ent_shift;
    logic [BW-1:0]             ent_bits;
    logic                      ent_level;
    logic [swlpe_pkg::POS_W-1:0] ent_k;
    logic                      ent_found;
    logic                      ent_bit;
    logic [TB-1:0]             tick_dec;

    function automatic logic [TB-1:0] sat_len(input logic [SW-1:0] v);
        if (v > TMAX_EXT) begin
            return TMAX_EXT[TB-1:0];
        end
        return v[TB-1:0];
    endfunction

    assign s_tready  = ~m_valid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, result_reg};
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg    <= swlpe_pkg::CFG_W'(1);
            gap_one_reg  <= swlpe_pkg::CFG_W'(1);
            gap_zero_reg <= swlpe_pkg::CFG_W'(3);
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                swlpe_pkg::REG_PULSE:    pulse_reg    <= pwdata[swlpe_pkg::CFG_W-1:0];
                swlpe_pkg::REG_GAP_ONE:  gap_one_reg  <= pwdata[swlpe_pkg::CFG_W-1:0];
                swlpe_pkg::REG_GAP_ZERO: gap_zero_reg <= pwdata[swlpe_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            swlpe_pkg::REG_PULSE:    prdata = swlpe_pkg::APB_W'(pulse_reg);
            swlpe_pkg::REG_GAP_ONE:  prdata = swlpe_pkg::APB_W'(gap_one_reg);
            swlpe_pkg::REG_GAP_ZERO: prdata = swlpe_pkg::APB_W'(gap_zero_reg);
            default:                 prdata = '0;
        endcase
    end

    // Segment lengths.
    assign seg_p  = sat_len(SW'(pulse_reg));
    assign seg_hl = sat_len(SW'(pulse_reg) + SW'(gap_zero_reg));
    assign seg_g1 = sat_len(SW'(gap_one_reg));
    assign seg_g0 = sat_len(SW'(gap_zero_reg));
    assign p_nz   = seg_p  != '0;
    assign hl_nz  = seg_hl != '0;
    assign g1_nz  = seg_g1 != '0;
    assign g0_nz  = seg_g0 != '0;

    // Source of the advance: a load behaves as an expired header pulse.
    always_comb begin
        if (s_tuser == swlpe_pkg::MODE_LOAD) begin
            adv_from     = swlpe_pkg::PH_HDR_HIGH;
            adv_shift_in = s_tdata;
            adv_bits_in  = BW'(BIT_TOTAL);
        end else begin
            adv_from     = phase_reg;
            adv_shift_in = shift_reg;
            adv_bits_in  = bits_reg;
        end
    end

    // Entry into the next bit: after the header nothing is consumed, after a
    // closing gap the current bit is shifted out.
    always_comb begin
        if (adv_from == swlpe_pkg::PH_HDR_HIGH || adv_from == swlpe_pkg::PH_HDR_LOW) begin
            ent_shift_in = adv_shift_in;
            ent_bits_in  = adv_bits_in;
        end else begin
            ent_shift_in = adv_shift_in << 1;
            ent_bits_in  = (adv_bits_in != '0) ? adv_bits_in - BW'(1) : adv_bits_in;
        end
    end

    // Bit entry. With a zero pulse length only the closing gaps take time, so
    // bits whose gap is zero are skipped by searching for the first bit that
    // has a non-zero gap.
    always_comb begin
        ent_k     = '0;
        ent_found = 1'b0;
        ent_bit   = ent_shift_in[WW-1];
        if (g1_nz && g0_nz) begin
            ent_found = 1'b1;
        end else if (g1_nz) begin
            ent_k     = swlpe_pkg::lead_pos(ent_shift_in, 1'b1);
            ent_found = ent_k != swlpe_pkg::POS_W'(WW);
            ent_bit   = 1'b1;
        end else if (g0_nz) begin
            // Past the word only zero bits remain.
            ent_k     = swlpe_pkg::lead_pos(ent_shift_in, 1'b0);
            ent_found = 1'b1;
            ent_bit   = 1'b0;
        end

        ent_shift = ent_shift_in;
        ent_bits  = ent_bits_in;
        ent_timer = '0;
        ent_level = 1'b0;
        ent_phase = swlpe_pkg::PH_IDLE;
        if (p_nz) begin
            if (ent_bits_in != '0) begin
                ent_phase = swlpe_pkg::PH_BIT_HIGH;
                ent_timer = seg_p;
                ent_level = 1'b1;
            end
        end else if (ent_found && (CW'(ent_k) < CW'(ent_bits_in))) begin
            ent_phase = ent_bit ? swlpe_pkg::PH_ONE_LOW : swlpe_pkg::PH_ZERO_LOW;
            ent_timer = ent_bit ? seg_g1 : seg_g0;
            ent_shift = ent_shift_in << ent_k;
            ent_bits  = BW'(CW'(ent_bits_in) - CW'(ent_k));
        end
    end

    // Phase that follows an expired segment. A pulse length that has dropped
    // to zero since the bit started skips the remaining pulse segments.
    always_comb begin
        adv_phase = ent_phase;
        adv_timer = ent_timer;
        adv_shift = ent_shift;
        adv_bits  = ent_bits;
        adv_level = ent_level;
        unique case (adv_from)
            swlpe_pkg::PH_HDR_HIGH: begin
                if (hl_nz) begin
                    adv_phase = swlpe_pkg::PH_HDR_LOW;
                    adv_timer = seg_hl;
                    adv_shift = adv_shift_in;
                    adv_bits  = adv_bits_in;
                    adv_level = 1'b0;
                end
            end
            swlpe_pkg::PH_BIT_HIGH: begin
                if (p_nz) begin
                    adv_phase = swlpe_pkg::PH_BIT_LOW;
                    adv_timer = seg_p;
                    adv_shift = adv_shift_in;
                    adv_bits  = adv_bits_in;
                    adv_level = 1'b0;
                end else if (adv_shift_in[WW-1]) begin
                    if (g1_nz) begin
                        adv_phase = swlpe_pkg::PH_ONE_LOW;
                        adv_timer = seg_g1;
                        adv_shift = adv_shift_in;
                        adv_bits  = adv_bits_in;
                        adv_level = 1'b0;
                    end
                end else if (g0_nz) begin
                    adv_phase = swlpe_pkg::PH_ZERO_LOW;
                    adv_timer = seg_g0;
                    adv_shift = adv_shift_in;
                    adv_bits  = adv_bits_in;
                    adv_level = 1'b0;
                end
            end
            swlpe_pkg::PH_BIT_LOW: begin
                if (adv_shift_in[WW-1]) begin
                    if (p_nz) begin
                        adv_phase = swlpe_pkg::PH_ONE_HIGH;
                        adv_timer = seg_p;
                        adv_shift = adv_shift_in;
                        adv_bits  = adv_bits_in;
                        adv_level = 1'b1;
                    end else if (g1_nz) begin
                        adv_phase = swlpe_pkg::PH_ONE_LOW;
                        adv_timer = seg_g1;
                        adv_shift = adv_shift_in;
                        adv_bits  = adv_bits_in;
                        adv_level = 1'b0;
                    end
                end else if (g0_nz) begin
                    adv_phase = swlpe_pkg::PH_ZERO_LOW;
                    adv_timer = seg_g0;
                    adv_shift = adv_shift_in;
                    adv_bits  = adv_bits_in;
                    adv_level = 1'b0;
                end
            end
            swlpe_pkg::PH_ONE_HIGH: begin
                if (g1_nz) begin
                    adv_phase = swlpe_pkg::PH_ONE_LOW;
                    adv_timer = seg_g1;
                    adv_shift = adv_shift_in;
                    adv_bits  = adv_bits_in;
                    adv_level = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign tick_dec = timer_reg - TB'(1);

    // Next sequencer state for the transfer being accepted.
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        level_next = level_reg;
        refused    = 1'b0;
        if (s_tuser == swlpe_pkg::MODE_LOAD) begin
            if (phase_reg != swlpe_pkg::PH_IDLE) begin
                refused = 1'b1;
            end else if (p_nz) begin
                phase_next = swlpe_pkg::PH_HDR_HIGH;
                timer_next = seg_p;
                shift_next = s_tdata;
                bits_next  = BW'(BIT_TOTAL);
                level_next = 1'b1;
            end else begin
                phase_next = adv_phase;
                timer_next = adv_timer;
                shift_next = adv_shift;
                bits_next  = adv_bits;
                level_next = adv_level;
            end
        end else if (phase_reg != swlpe_pkg::PH_IDLE) begin
            if (tick_dec != '0) begin
                timer_next = tick_dec;
            end else begin
                phase_next = adv_phase;
                timer_next = adv_timer;
                shift_next = adv_shift;
                bits_next  = adv_bits;
                level_next = adv_level;
            end
        end
    end

    always_comb begin
        result_next = '0;
        result_next[swlpe_pkg::OUT_LEVEL_BIT]   = level_next;
        result_next[swlpe_pkg::OUT_BUSY_BIT]    = phase_next != swlpe_pkg::PH_IDLE;
        result_next[swlpe_pkg::OUT_REFUSED_BIT] = refused;
    end

    // Sequencer control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= swlpe_pkg::PH_IDLE;
            timer_reg <= '0;
            bits_reg  <= '0;
            level_reg <= 1'b0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bits_reg  <= bits_next;
            level_reg <= level_next;
        end
    end

    // Frame word and result payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            shift_reg  <= shift_next;
            result_reg <= result_next;
        end
    end

    // Result valid: set by an accepted item, cleared when the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

### src/swlpe_checker.sv
// Port-level checker for the single-wire LED pulse encoder and its bind.
`include "assert_macros.svh"

module swlpe_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [7:0]                   m_tdata
);

    logic in_xfer;
    logic held;
    logic out_level;
    logic out_busy;
    logic out_refused;

    assign in_xfer     = s_tvalid && s_tready;
    assign held        = m_tvalid && !m_tready;
    assign out_level   = m_tvalid && m_tdata[swlpe_pkg::OUT_LEVEL_BIT];
    assign out_busy    = m_tdata[swlpe_pkg::OUT_BUSY_BIT];
    assign out_refused = m_tvalid && m_tdata[swlpe_pkg::OUT_REFUSED_BIT];

    // A held result keeps its value until the transfer completes.
    `SWLPE_ASSERT_NXT(held_result_stable, aclk, aresetn, held, m_tvalid && $stable(m_tdata))

    // Every accepted item leaves a result behind in the next cycle.
    `SWLPE_ASSERT_NXT(result_after_input, aclk, aresetn, in_xfer, m_tvalid)

    // With the result register empty the block always takes the next item.
    `SWLPE_ASSERT_IMP(ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // The line is only driven high while a frame is in progress.
    `SWLPE_ASSERT_IMP(high_only_busy, aclk, aresetn, out_level, out_busy)

    // A refused load can only be reported while a frame is being sent.
    `SWLPE_ASSERT_IMP(refused_only_busy, aclk, aresetn, out_refused, out_busy)

endmodule

bind single_wire_led_pulse_encoder_core swlpe_checker u_swlpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/single_wire_led_pulse_encoder_core_test.sv
// Self-checking testbench for the single-wire LED pulse encoder core.
module single_wire_led_pulse_encoder_core_test;

    localparam int WORD_W      = swlpe_pkg::WORD_W;
    localparam int CFG_W       = swlpe_pkg::CFG_W;
    localparam int POS_W       = swlpe_pkg::POS_W;
    localparam int APB_W       = swlpe_pkg::APB_W;
    localparam int SEG_W       = swlpe_pkg::DEF_TIMER_BITS;
    localparam int FRAME_BITS  = swlpe_pkg::DEF_FRAME_BYTES * 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 10;

    localparam logic [SEG_W-1:0] SEG_MAX = '1;

    typedef struct {
        logic              mode;
        logic [WORD_W-1:0] word;
    } line_item_t;

    typedef struct packed {
        logic refused;
        logic busy;
        logic level;
    } line_result_t;

    // Clock and reset.
    logic aclk;
    logic aresetn;

    // Input stream.
    logic              s_tvalid;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata;    // [31:0] gs_word
    logic              s_tuser;    // [0] mode

    // Result stream.
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;           // [0] line_level, [1] busy_res, [2] load_refused

    // Configuration port.
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [swlpe_pkg::ADDR_W-1:0] paddr;
    logic [APB_W-1:0]             pwdata;
    logic [APB_W-1:0]             prdata;
    logic                         pready;

    // Shadow copy of the registers, updated from observed register writes.
    logic [CFG_W-1:0] pulse_len;
    logic [CFG_W-1:0] gap_one_len;
    logic [CFG_W-1:0] gap_zero_len;

    // Shadow copy of the line sequencer.
    logic [WORD_W-1:0] frame_word;
    logic [POS_W-1:0]  bits_to_send;
    logic [2:0]        line_phase;
    logic [SEG_W-1:0]  seg_timer;
    logic              line_lvl;

    // Stimulus and scoreboard bookkeeping.
    line_item_t   items_to_send[$];
    line_result_t line_results_due[$];
    int           items_queued;
    int           results_checked;
    int           mismatch_count;
    int           quiet_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         in_taken;

    single_wire_led_pulse_encoder_core #(
        .FRAME_BYTES (swlpe_pkg::DEF_FRAME_BYTES),
        .TIMER_BITS  (swlpe_pkg::DEF_TIMER_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Segment lengths saturate at the largest value the timer holds.
    function automatic logic [SEG_W-1:0] clip_length(input int unsigned len);
        if (len > SEG_MAX) begin
            return SEG_MAX;
        end
        return SEG_W'(len);
    endfunction

    // Load the line level and the segment timer for the current phase.
    function void load_segment();
        case (line_phase)
            swlpe_pkg::PH_HDR_HIGH, swlpe_pkg::PH_BIT_HIGH, swlpe_pkg::PH_ONE_HIGH: begin
                line_lvl  = 1'b1;
                seg_timer = clip_length(pulse_len);
            end
            swlpe_pkg::PH_HDR_LOW: begin
                line_lvl  = 1'b0;
                seg_timer = clip_length(int'(pulse_len) + int'(gap_zero_len));
            end
            swlpe_pkg::PH_BIT_LOW: begin
                line_lvl  = 1'b0;
                seg_timer = clip_length(pulse_len);
            end
            swlpe_pkg::PH_ONE_LOW: begin
                line_lvl  = 1'b0;
                seg_timer = clip_length(gap_one_len);
            end
            swlpe_pkg::PH_ZERO_LOW: begin
                line_lvl  = 1'b0;
                seg_timer = clip_length(gap_zero_len);
            end
            default: begin
                line_phase = swlpe_pkg::PH_IDLE;
                line_lvl   = 1'b0;
                seg_timer  = '0;
            end
        endcase
    endfunction

    // Move on to the segment that follows the current one.
    function void advance_segment();
        case (line_phase)
            swlpe_pkg::PH_HDR_HIGH: line_phase = swlpe_pkg::PH_HDR_LOW;
            swlpe_pkg::PH_HDR_LOW:
                line_phase = (bits_to_send != 0) ? swlpe_pkg::PH_BIT_HIGH : swlpe_pkg::PH_IDLE;
            swlpe_pkg::PH_BIT_HIGH: line_phase = swlpe_pkg::PH_BIT_LOW;
            swlpe_pkg::PH_BIT_LOW:
                line_phase = frame_word[WORD_W-1] ? swlpe_pkg::PH_ONE_HIGH
                                                  : swlpe_pkg::PH_ZERO_LOW;
            swlpe_pkg::PH_ONE_HIGH: line_phase = swlpe_pkg::PH_ONE_LOW;
            swlpe_pkg::PH_ONE_LOW, swlpe_pkg::PH_ZERO_LOW: begin
                frame_word = frame_word << 1;
                if (bits_to_send != 0) begin
                    bits_to_send = bits_to_send - 1'b1;
                end
                line_phase = (bits_to_send != 0) ? swlpe_pkg::PH_BIT_HIGH : swlpe_pkg::PH_IDLE;
            end
            default: line_phase = swlpe_pkg::PH_IDLE;
        endcase
        load_segment();
    endfunction

    // Work out the line state that one item leaves behind.
    function line_result_t encode_item(input logic mode, input logic [WORD_W-1:0] word);
        line_result_t res;
        res.refused = 1'b0;
        if (mode == swlpe_pkg::MODE_LOAD) begin
            if (line_phase != swlpe_pkg::PH_IDLE) begin
                res.refused = 1'b1;
            end else begin
                frame_word   = word;
                bits_to_send = POS_W'(FRAME_BITS);
                line_phase   = swlpe_pkg::PH_HDR_HIGH;
                load_segment();
                while (line_phase != swlpe_pkg::PH_IDLE && seg_timer == 0) advance_segment();
            end
        end else if (line_phase != swlpe_pkg::PH_IDLE) begin
            if (seg_timer != 0) begin
                seg_timer = seg_timer - 1'b1;
            end
            while (line_phase != swlpe_pkg::PH_IDLE && seg_timer == 0) advance_segment();
        end
        res.level = line_lvl;
        res.busy  = (line_phase != swlpe_pkg::PH_IDLE);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Observe transfers at the rising edge: check results, predict new ones.
    always @(posedge aclk) begin : observe
        line_result_t due;
        logic         transferred;
        if (!aresetn) begin
            in_taken     = 1'b0;
            quiet_cycles = 0;
            pulse_len    = CFG_W'(1);
            gap_one_len  = CFG_W'(1);
            gap_zero_len = CFG_W'(3);
            frame_word   = '0;
            bits_to_send = '0;
            line_phase   = swlpe_pkg::PH_IDLE;
            seg_timer    = '0;
            line_lvl     = 1'b0;
        end else begin
            transferred = 1'b0;
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    swlpe_pkg::REG_PULSE:    pulse_len    = pwdata[CFG_W-1:0];
                    swlpe_pkg::REG_GAP_ONE:  gap_one_len  = pwdata[CFG_W-1:0];
                    swlpe_pkg::REG_GAP_ZERO: gap_zero_len = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                transferred = 1'b1;
                if (line_results_due.size() == 0) begin
                    report_mismatch($sformatf("result 0x%02h with none expected", m_tdata));
                end else begin
                    due = line_results_due.pop_front();
                    if (m_tdata[swlpe_pkg::OUT_LEVEL_BIT] !== due.level)
                        report_mismatch($sformatf("line_level exp %0b got %0b",
                                                  due.level,
                                                  m_tdata[swlpe_pkg::OUT_LEVEL_BIT]));
                    if (m_tdata[swlpe_pkg::OUT_BUSY_BIT] !== due.busy)
                        report_mismatch($sformatf("busy_res exp %0b got %0b",
                                                  due.busy,
                                                  m_tdata[swlpe_pkg::OUT_BUSY_BIT]));
                    if (m_tdata[swlpe_pkg::OUT_REFUSED_BIT] !== due.refused)
                        report_mismatch($sformatf("load_refused exp %0b got %0b",
                                                  due.refused,
                                                  m_tdata[swlpe_pkg::OUT_REFUSED_BIT]));
                    if (m_tdata[7:swlpe_pkg::OUT_REFUSED_BIT+1] !== '0)
                        report_mismatch($sformatf("padding bits not zero: 0x%02h", m_tdata));
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                transferred = 1'b1;
                line_results_due.push_back(encode_item(s_tuser, s_tdata));
            end
            in_taken     = s_tvalid && s_tready;
            quiet_cycles = transferred ? 0 : quiet_cycles + 1;
        end
    end

    // Drive the input stream and the result back-pressure at the falling edge.
    always @(negedge aclk) begin : drive
        line_item_t item;
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = items_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.word;
                    s_tuser  <= item.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when nothing has moved for too long.
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("single_wire_led_pulse_encoder_core: mismatch");
        $finish;
    end

    task automatic push_item(input logic mode, input logic [WORD_W-1:0] word);
        line_item_t item;
        item.mode = mode;
        item.word = word;
        items_to_send.push_back(item);
        items_queued++;
    endtask

    // Wait until every queued transfer has produced its checked result.
    task automatic wait_drained();
        do @(negedge aclk); while (results_checked != items_queued);
    endtask

    // Keep ticking until the frame in flight has ended.
    task automatic finish_frame();
        wait_drained();
        while (line_phase != swlpe_pkg::PH_IDLE) begin
            repeat (16) push_item(swlpe_pkg::MODE_TICK, $urandom);
            wait_drained();
        end
    endtask

    // Register write: setup cycle then access cycle; upper data bits are junk.
    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {$urandom} & ~{{(APB_W-CFG_W){1'b0}}, {CFG_W{1'b1}}} | val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] gap_one,
                              input logic [CFG_W-1:0] gap_zero);
        cfg_write(swlpe_pkg::REG_PULSE, pulse);
        cfg_write(swlpe_pkg::REG_GAP_ONE, gap_one);
        cfg_write(swlpe_pkg::REG_GAP_ZERO, gap_zero);
    endtask

    function automatic logic [WORD_W-1:0] frame_pattern();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly whole frames of ticks, with stray loads mixed in.
    task automatic run_random_frames(input int count);
        int phase_start;
        int n_ticks;
        phase_start = items_queued;
        while (items_queued - phase_start < count) begin
            push_item(swlpe_pkg::MODE_LOAD, frame_pattern());
            n_ticks = $urandom_range(8, 90);
            repeat (n_ticks) begin
                if ($urandom_range(99) < 5)
                    push_item(swlpe_pkg::MODE_LOAD, frame_pattern());
                else
                    push_item(swlpe_pkg::MODE_TICK, $urandom);
            end
            if ($urandom_range(1) == 1) finish_frame();
        end
        finish_frame();
    endtask

    initial begin : stimulus
        int idle_plan[4][2];
        idle_plan = '{'{0, 0}, '{87, 0}, '{0, 87}, '{31, 31}};

        // Known values on every input from the start.
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = swlpe_pkg::MODE_TICK;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        items_queued    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: every segment empty, so a load ends within its own transfer.
        set_timing(12'd0, 12'd0, 12'd0);
        push_item(swlpe_pkg::MODE_TICK, $urandom);
        push_item(swlpe_pkg::MODE_LOAD, '1);
        push_item(swlpe_pkg::MODE_LOAD, '0);
        push_item(swlpe_pkg::MODE_TICK, '1);
        wait_drained();

        // Directed: only the header low segment and the zero gaps last; a second load is refused.
        set_timing(12'd0, 12'd0, 12'd1);
        push_item(swlpe_pkg::MODE_LOAD, 32'h7FFF_FFFF);
        push_item(swlpe_pkg::MODE_LOAD, 32'h8000_0000);
        repeat (3) push_item(swlpe_pkg::MODE_TICK, $urandom);
        finish_frame();

        // Directed: reset timing, tick while idle, then a frame with a refused load.
        set_timing(12'd1, 12'd1, 12'd3);
        push_item(swlpe_pkg::MODE_TICK, $urandom);
        push_item(swlpe_pkg::MODE_LOAD, 32'h8000_0001);
        repeat (3) push_item(swlpe_pkg::MODE_TICK, $urandom);
        push_item(swlpe_pkg::MODE_LOAD, 32'h5A5A_A5A5);
        push_item(swlpe_pkg::MODE_TICK, $urandom);
        finish_frame();

        // Random phases, each with its own timing and idling pattern.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            set_timing(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 3)),
                       CFG_W'($urandom_range(0, 3)));
            run_random_frames(60);
        end

        // Largest timing: the frame cannot finish, so it is the last phase.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_timing('1, '1, '1);
        push_item(swlpe_pkg::MODE_LOAD, frame_pattern());
        repeat (20) push_item(swlpe_pkg::MODE_TICK, $urandom);
        push_item(swlpe_pkg::MODE_LOAD, frame_pattern());
        repeat (5) push_item(swlpe_pkg::MODE_TICK, $urandom);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (line_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", line_results_due.size()));
        if (mismatch_count == 0)
            $display("single_wire_led_pulse_encoder_core: match");
        else
            $display("single_wire_led_pulse_encoder_core: mismatch");
        $finish;
    end

endmodule
